/* rtl/core/sweep_grid_next_index_top_assert.svh */
// Assertion macros for the grid walk address generator.
// Expect signals clk and rst in the scope of each use.
`ifndef SWEEP_GRID_NEXT_INDEX_TOP_ASSERT_SVH
`define SWEEP_GRID_NEXT_INDEX_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SGNI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SGNI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGNI_ASSERT(lbl, prop, msg)
`define SGNI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/core/sgni_pkg.sv */
// Shared types and constants for the grid walk address generator.
// No dependencies.
`timescale 1ns / 1ps
package sgni_pkg;
  localparam int NUM_DIMS  = 3;
  localparam int IDX_W     = 25;
  localparam int EXT_W     = 9;
  localparam int CRD_W     = EXT_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int FACE_W    = 3;
  localparam int EXT_MIN   = 3;
  localparam int EXT_MAX   = 256;

  localparam logic CMD_SWEEP = 1'b0;
  localparam logic CMD_FACE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2 = 2'd2;

  typedef struct packed {
    logic                 cmd;
    logic [IDX_W-1:0]     current_index;
    logic [NUM_DIMS-1:0]  sweep_dir;
    logic [FACE_W-1:0]    boundary_face;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] next_index;
    logic             walk_done;
  } out_item_t;

  // Command fields plus one coordinate carried alongside a divider.
  typedef struct packed {
    logic                cmd;
    logic [NUM_DIMS-1:0] dir;
    logic [FACE_W-1:0]   face;
    logic [EXT_W-1:0]    lo;
  } side_t;
endpackage

/* rtl/core/sweep_grid_next_index_top.sv */
// Grid walk address generator: next index of an interior sweep or face walk.
// One item per cycle while the output is not stalled.
// Two 25-stage pipelined dividers, one quotient bit per stage, split the index.
// A stalled output freezes the whole pipeline; input stalls with it.
// Synchronous reset clears all valid bits and sets every extent to 256.
`timescale 1ns / 1ps
`include "sweep_grid_next_index_top_assert.svh"
module sweep_grid_next_index_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sgni_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sgni_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [sgni_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgni_pkg::EXT_W-1:0]    cfg_data
);
  import sgni_pkg::*;

  // Global advance: every stage moves unless the output holds a stalled result.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- configuration ----------------
  logic [EXT_W-1:0] ext_reg [NUM_DIMS];
  logic [EXT_W-1:0] ext_q   [NUM_DIMS];
  logic [2*EXT_W-1:0] n01_q;
  logic [IDX_W-1:0]   n_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        ext_reg[d] <= EXT_W'(EXT_MAX);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXTENT_0: ext_reg[0] <= cfg_data;
        CFG_EXTENT_1: ext_reg[1] <= cfg_data;
        CFG_EXTENT_2: ext_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp extents into the legal range, then form the point count.
  // The clamped extents and the point count are registered, so they lag an extent write.
  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (ext_reg[d] < EXT_W'(EXT_MIN)) begin
        ext_q[d] <= EXT_W'(EXT_MIN);
      end else if (ext_reg[d] > EXT_W'(EXT_MAX)) begin
        ext_q[d] <= EXT_W'(EXT_MAX);
      end else begin
        ext_q[d] <= ext_reg[d];
      end
    end
    n01_q <= ext_q[0] * ext_q[1];
    n_q   <= IDX_W'(n01_q * ext_q[2]);
  end

  // ---------------- input register ----------------
  logic     s0_valid;
  in_item_t s0_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_data <= in_data;
    end
  end

  // ---------------- index split ----------------
  // First divide by extent 2 (its remainder is coordinate 2), then the
  // quotient by extent 1 (remainder is coordinate 1, quotient coordinate 0).
  side_t            s0_side;
  logic             d1_valid;
  logic [IDX_W-1:0] d1_quo;
  logic [EXT_W-1:0] d1_rem;
  side_t            d1_side;
  side_t            d2_side_in;
  logic             d2_valid;
  logic [IDX_W-1:0] d2_quo;
  logic [EXT_W-1:0] d2_rem;
  side_t            d2_side;

  assign s0_side = '{cmd: s0_data.cmd, dir: s0_data.sweep_dir,
                     face: s0_data.boundary_face, lo: '0};

  sgni_divider u_div_lo (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s0_valid),
    .in_num   (s0_data.current_index),
    .in_den   (ext_q[2]),
    .in_side  (s0_side),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem),
    .out_side (d1_side)
  );

  // Carry coordinate 2 alongside the second division.
  always_comb begin
    d2_side_in    = d1_side;
    d2_side_in.lo = d1_rem;
  end

  sgni_divider u_div_hi (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (d1_valid),
    .in_num   (d1_quo),
    .in_den   (ext_q[1]),
    .in_side  (d2_side_in),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_rem  (d2_rem),
    .out_side (d2_side)
  );

  // ---------------- step stage ----------------
  logic signed [CRD_W-1:0] e_s  [NUM_DIMS];
  logic signed [CRD_W-1:0] p_s  [NUM_DIMS];
  logic signed [CRD_W-1:0] sw   [NUM_DIMS];
  logic signed [CRD_W-1:0] fc   [NUM_DIMS];
  logic signed [CRD_W-1:0] st_c [NUM_DIMS];
  logic                    start;
  logic                    sw_go;
  logic                    sw_fin;
  logic                    fc_fin;
  logic                    st_fin;
  logic [1:0]              bdim;
  logic [1:0]              a0;
  logic [1:0]              a1;
  logic                    high_face;

  // Index at or above the count shows up as a top quotient past extent 0.
  assign start = (d2_quo >= IDX_W'(ext_q[0]));

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      e_s[d] = signed'({1'b0, ext_q[d]});
    end
    p_s[0] = signed'({1'b0, d2_quo[EXT_W-1:0]});
    p_s[1] = signed'({1'b0, d2_rem});
    p_s[2] = signed'({1'b0, d2_side.lo});

    // Interior sweep: step dimension 0, carry on leaving the interior.
    sw     = p_s;
    sw_go  = 1'b1;
    sw_fin = 1'b0;
    if (start) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        sw[d] = d2_side.dir[d] ? e_s[d] - CRD_W'(2) : CRD_W'(1);
      end
    end else begin
      sw[0] = d2_side.dir[0] ? sw[0] - CRD_W'(1) : sw[0] + CRD_W'(1);
      for (int d = 0; d < NUM_DIMS - 1; d++) begin
        if (sw_go) begin
          if (sw[d] >= CRD_W'(1) && sw[d] <= e_s[d] - CRD_W'(2)) begin
            sw_go = 1'b0;
          end else begin
            sw[d]   = d2_side.dir[d] ? e_s[d] - CRD_W'(2) : CRD_W'(1);
            sw[d+1] = d2_side.dir[d+1] ? sw[d+1] - CRD_W'(1) : sw[d+1] + CRD_W'(1);
          end
        end
      end
      sw_fin = !(sw[NUM_DIMS-1] >= CRD_W'(1) &&
                 sw[NUM_DIMS-1] <= e_s[NUM_DIMS-1] - CRD_W'(2));
    end

    // Face walk: step the dimension after the face, carry cyclically.
    high_face = (d2_side.face >= FACE_W'(NUM_DIMS));
    bdim      = high_face ? 2'(d2_side.face - FACE_W'(NUM_DIMS)) : d2_side.face[1:0];
    a0        = (bdim == 2'd2) ? 2'd0 : bdim + 2'd1;
    a1        = (bdim == 2'd0) ? 2'd2 : bdim - 2'd1;
    fc        = p_s;
    fc_fin    = 1'b0;
    if (d2_side.face >= FACE_W'(2 * NUM_DIMS)) begin
      fc_fin = 1'b1;
    end else if (start) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        fc[d] = '0;
      end
      if (high_face) begin
        fc[bdim] = e_s[bdim] - CRD_W'(1);
      end
    end else begin
      fc[a0] = fc[a0] + CRD_W'(1);
      if (fc[a0] >= e_s[a0]) begin
        fc[a0] = '0;
        fc[a1] = fc[a1] + CRD_W'(1);
      end
      fc_fin = (fc[a1] >= e_s[a1]);
    end

    if (d2_side.cmd == CMD_SWEEP) begin
      st_c   = sw;
      st_fin = sw_fin;
    end else begin
      st_c   = fc;
      st_fin = fc_fin;
    end
  end

  logic             c_valid;
  logic             c_fin;
  logic             c_cmd;
  logic [EXT_W-1:0] c_p [NUM_DIMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_fin <= st_fin;
      c_cmd <= d2_side.cmd;
      for (int d = 0; d < NUM_DIMS; d++) begin
        c_p[d] <= st_c[d][EXT_W-1:0];
      end
    end
  end

  // ---------------- index join ----------------
  logic                 j1_valid;
  logic                 j1_fin;
  logic [2*EXT_W-1:0]   j1_acc;
  logic [EXT_W-1:0]     j1_p2;
  logic [3*EXT_W-1:0]   j2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      j1_valid <= 1'b0;
    end else if (adv) begin
      j1_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j1_acc <= (2*EXT_W)'(c_p[0] * ext_q[1]) + (2*EXT_W)'(c_p[1]);
      j1_p2  <= c_p[2];
      j1_fin <= c_fin;
    end
  end

  assign j2_sum = (3*EXT_W)'(j1_acc * ext_q[2]) + (3*EXT_W)'(j1_p2);

  // Output register: drive the sentinel when the walk is finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= j1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.next_index <= j1_fin ? n_q : j2_sum[IDX_W-1:0];
      out_data.walk_done  <= j1_fin;
    end
  end

  // ---------------- checks ----------------
  `SGNI_ASSERT_RST(a_rst_clears_out, rst |=> !out_valid, "output valid after reset")
  `SGNI_ASSERT(a_done_matches, out_valid |-> (out_data.walk_done == (out_data.next_index == n_q)), "walk_done disagrees with sentinel")
  `SGNI_ASSERT(a_live_below_count, out_valid && !out_data.walk_done |-> (out_data.next_index < n_q), "live index at or above count")
  `SGNI_ASSERT(a_rem_range, d2_valid |-> (d2_rem < ext_q[1]), "divider remainder not below extent")
  `SGNI_ASSERT(a_sweep_interior, c_valid && !c_fin && (c_cmd == CMD_SWEEP) |-> (c_p[0] >= 9'd1 && c_p[0] <= ext_q[0] - 9'd2), "sweep step left the interior")
endmodule

/* rtl/core/sgni_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sgni_pkg; divisor must hold steady while items are in flight.
`timescale 1ns / 1ps
module sgni_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [sgni_pkg::IDX_W-1:0] in_num,
  input  logic [sgni_pkg::EXT_W-1:0] in_den,
  input  sgni_pkg::side_t           in_side,
  output logic                      out_valid,
  output logic [sgni_pkg::IDX_W-1:0] out_quo,
  output logic [sgni_pkg::EXT_W-1:0] out_rem,
  output sgni_pkg::side_t           out_side
);
  import sgni_pkg::*;

  logic             v_q    [IDX_W];
  logic [IDX_W-1:0] quo_q  [IDX_W];
  logic [EXT_W-1:0] rem_q  [IDX_W];
  side_t            side_q [IDX_W];
  logic [IDX_W-1:0] num_q  [IDX_W-1];

  for (genvar k = 0; k < IDX_W; k++) begin : g_step
    logic             v_in;
    logic [IDX_W-1:0] n_in;
    logic [IDX_W-1:0] q_in;
    logic [EXT_W-1:0] r_in;
    side_t            s_in;
    logic [EXT_W:0]   pr;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = in_num;
      assign q_in = '0;
      assign r_in = '0;
      assign s_in = in_side;
    end else begin : g_rest
      assign v_in = v_q[k-1];
      assign n_in = num_q[k-1];
      assign q_in = quo_q[k-1];
      assign r_in = rem_q[k-1];
      assign s_in = side_q[k-1];
    end

    // Shift in the next dividend bit, subtract when the divisor fits.
    assign pr = {r_in, n_in[IDX_W-1-k]};
    assign ge = (pr >= {1'b0, in_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (adv) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_q[k]  <= {q_in[IDX_W-2:0], ge};
        rem_q[k]  <= ge ? EXT_W'(pr - {1'b0, in_den}) : pr[EXT_W-1:0];
        side_q[k] <= s_in;
      end
    end

    if (k < IDX_W - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (adv) begin
          num_q[k] <= n_in;
        end
      end
    end
  end

  assign out_valid = v_q[IDX_W-1];
  assign out_quo   = quo_q[IDX_W-1];
  assign out_rem   = rem_q[IDX_W-1];
  assign out_side  = side_q[IDX_W-1];
endmodule

/* dv/sweep_grid_next_index_top_tb.sv */
// Self-checking testbench for the grid walk address generator.
// Depends on sgni_pkg and sweep_grid_next_index_top; predicts each next index in-line.
`timescale 1ns / 1ps
module sweep_grid_next_index_top_tb;
  import sgni_pkg::*;

  localparam int LATENCY = 54;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_EXTENT_0;
  logic [EXT_W-1:0] cfg_data = '0;

  // Extents as written; the predictor clamps them at use.
  logic [EXT_W-1:0] extent_regs [NUM_DIMS];
  out_item_t expected_q [$];
  int error_count = 0;
  int result_count = 0;
  int item_count = 0;
  int cycle_count = 0;
  // Idling controls: percent of cycles idle; hold counts a forced receiver stall.
  int send_idle_pct = 24;
  int recv_idle_pct = 24;
  int recv_hold = 0;

  sweep_grid_next_index_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sweep_grid_next_index_top_tb: errors");
      $finish;
    end
  end

  function automatic longint clamped_extent(int d);
    longint v;
    v = extent_regs[d];
    if (v < EXT_MIN) v = EXT_MIN;
    if (v > EXT_MAX) v = EXT_MAX;
    return v;
  endfunction

  function automatic longint point_count();
    return clamped_extent(0) * clamped_extent(1) * clamped_extent(2);
  endfunction

  function automatic bit is_inner(longint c, longint ext);
    return c >= 1 && c <= ext - 2;
  endfunction

  // Compute the next walk index for one request.
  function automatic out_item_t next_walk_index(in_item_t item);
    longint ext [NUM_DIMS];
    longint crd [NUM_DIMS];
    longint n, idx, nxt;
    int bdim, a, b, last;
    bit down;
    out_item_t r;
    for (int d = 0; d < NUM_DIMS; d++) ext[d] = clamped_extent(d);
    n = ext[0] * ext[1] * ext[2];
    idx = item.current_index;
    nxt = -1;
    if (idx < n) begin
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
        crd[d] = idx % ext[d];
        idx = idx / ext[d];
      end
    end
    if (item.cmd == CMD_SWEEP) begin
      if (item.current_index >= n) begin
        for (int d = 0; d < NUM_DIMS; d++)
          crd[d] = item.sweep_dir[d] ? ext[d] - 2 : 1;
      end else begin
        crd[0] += item.sweep_dir[0] ? -1 : 1;
        for (int d = 0; d < NUM_DIMS - 1; d++) begin
          if (is_inner(crd[d], ext[d])) break;
          crd[d] = item.sweep_dir[d] ? ext[d] - 2 : 1;
          down = item.sweep_dir[d+1];
          crd[d+1] += down ? -1 : 1;
        end
        if (!is_inner(crd[NUM_DIMS-1], ext[NUM_DIMS-1])) nxt = n;
      end
    end else if (item.boundary_face >= 2 * NUM_DIMS) begin
      nxt = n;
    end else begin
      bdim = item.boundary_face >= NUM_DIMS ? item.boundary_face - NUM_DIMS
                                            : item.boundary_face;
      if (item.current_index >= n) begin
        for (int d = 0; d < NUM_DIMS; d++) crd[d] = 0;
        if (item.boundary_face >= NUM_DIMS) crd[bdim] = ext[bdim] - 1;
      end else begin
        // Step the dimension after the face; carry cyclically.
        crd[(bdim + 1) % NUM_DIMS] += 1;
        for (int k = 0; k + 2 < NUM_DIMS; k++) begin
          a = (bdim + k + 1) % NUM_DIMS;
          b = (bdim + k + 2) % NUM_DIMS;
          if (crd[a] >= ext[a]) begin
            crd[a] = 0;
            crd[b] += 1;
          end
        end
        last = (bdim + NUM_DIMS - 1) % NUM_DIMS;
        if (crd[last] >= ext[last]) nxt = n;
      end
    end
    if (nxt < 0) begin
      nxt = 0;
      for (int d = 0; d < NUM_DIMS; d++) nxt = nxt * ext[d] + crd[d];
    end
    r.next_index = nxt[IDX_W-1:0];
    r.walk_done = (nxt == n);
    return r;
  endfunction

  // Receiver: stall at random, or for a forced hold stretch.
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (expected_q.size() == 0) begin
        $error("unexpected result next_index=%0d", out_data.next_index);
        error_count <= error_count + 1;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_data.next_index !== exp_item.next_index) begin
          $error("next_index expected %0d actual %0d",
                 exp_item.next_index, out_data.next_index);
          error_count <= error_count + 1;
        end
        if (out_data.walk_done !== exp_item.walk_done) begin
          $error("walk_done expected %0b actual %0b",
                 exp_item.walk_done, out_data.walk_done);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Offer one item, idling first at random; return once it transfers.
  // Valid stays high afterwards; the next send or a drain decides its level.
  task automatic send_item(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(next_walk_index(item));
    item_count++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_extent(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    extent_regs[idx] = val;
  endtask

  task automatic set_extents(int e0, int e1, int e2);
    wait_drained();
    write_extent(CFG_EXTENT_0, e0[EXT_W-1:0]);
    write_extent(CFG_EXTENT_1, e1[EXT_W-1:0]);
    write_extent(CFG_EXTENT_2, e2[EXT_W-1:0]);
  endtask

  function automatic in_item_t make_item(bit cmd, longint idx, int dir, int face);
    in_item_t it;
    it.cmd = cmd;
    it.current_index = idx[IDX_W-1:0];
    it.sweep_dir = dir[NUM_DIMS-1:0];
    it.boundary_face = face[FACE_W-1:0];
    return it;
  endfunction

  // Random index: mostly inside the grid, sometimes at or past the sentinel.
  function automatic longint pick_index();
    longint n;
    n = point_count();
    case ($urandom_range(9))
      0: return n;
      1: return $urandom_range(2 ** IDX_W - 1);
      2: return n - 1;
      default: return $urandom_range(n - 1);
    endcase
  endfunction

  // Directed corners: sentinels, extremes, every face, undefined faces.
  task automatic test_directed();
    longint n;
    set_extents(4, 5, 6);
    n = point_count();
    for (int f = 0; f < 8; f++) send_item(make_item(CMD_FACE, n, 0, f));
    send_item(make_item(CMD_FACE, n - 1, 0, 5));
    send_item(make_item(CMD_FACE, 0, 0, 0));
    for (int d = 0; d < 8; d += 3) send_item(make_item(CMD_SWEEP, n, d, 0));
    send_item(make_item(CMD_SWEEP, 0, 7, 7));
    send_item(make_item(CMD_SWEEP, n - 1, 0, 0));
    send_item(make_item(CMD_SWEEP, 2 ** IDX_W - 1, 7, 0));
    send_item(make_item(CMD_SWEEP, 1 * 30 + 1 * 6 + 4, 0, 0));
    send_item(make_item(CMD_SWEEP, 2 * 30 + 3 * 6 + 4, 0, 0));
    send_item(make_item(CMD_SWEEP, 1 * 30 + 1 * 6 + 1, 7, 0));
    // Clamped extents: 0 acts as the minimum, 511 as the maximum.
    set_extents(0, 511, 256);
    send_item(make_item(CMD_SWEEP, point_count() - 1, 2, 0));
    send_item(make_item(CMD_FACE, point_count() - 1, 0, 3));
  endtask

  // Chained walk segments from random start indices, plus random noise items.
  task automatic test_walks(int items);
    in_item_t it;
    out_item_t r;
    int left;
    left = items;
    while (left > 0) begin
      if ($urandom_range(3) == 0) begin
        send_item(make_item($urandom_range(1), pick_index(), $urandom_range(7),
                            $urandom_range(7)));
        left--;
      end else begin
        // Chain a walk segment using the predicted next index.
        it = make_item($urandom_range(1), pick_index(), $urandom_range(7),
                       $urandom_range(5));
        for (int k = 0; k < 12 && left > 0; k++) begin
          send_item(it);
          left--;
          r = next_walk_index(it);
          it.current_index = r.next_index;
        end
      end
    end
  endtask

  // Hold the receiver so the pipeline fills and stalls the input.
  task automatic test_backpressure();
    recv_hold = 200;
    test_walks(120);
  endtask

  // Pause the sender until every result is back, then resume unthrottled.
  task automatic test_no_idle();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_walks(150);
    send_idle_pct = 24;
    recv_idle_pct = 24;
  endtask

  initial begin
    for (int d = 0; d < NUM_DIMS; d++) extent_regs[d] = EXT_MAX;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_extents(3, 3, 3);
    test_walks(80);
    set_extents(256, 256, 256);
    test_walks(120);
    set_extents(5, 7, 4);
    test_backpressure();
    set_extents($urandom_range(3, 12), $urandom_range(3, 12), $urandom_range(3, 12));
    test_no_idle();
    set_extents($urandom_range(0, 511), $urandom_range(3, 40), $urandom_range(3, 40));
    test_walks(300);
    wait_drained();
    $display("covered %0d items and %0d results over seven extent settings,",
             item_count, result_count);
    $display("sweep and face walks, sentinels, clamping, stalls and hold-offs");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("sweep_grid_next_index_top_tb: clean");
    end else begin
      $display("sweep_grid_next_index_top_tb: errors");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/sgni_pkg.sv
rtl/core/sgni_divider.sv
rtl/core/sweep_grid_next_index_top.sv
dv/sweep_grid_next_index_top_tb.sv
